### hdl/kslt_pkg.sv
// Types and constants shared by the keyboard serial link transmitter.
package kslt_pkg;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'd0,
        PH_SYNC_REL   = 5'd1,
        PH_SYNC_DLOW  = 5'd2,
        PH_SYNC_CLOW  = 5'd3,
        PH_SYNC_CHIGH = 5'd4,
        PH_SYNC_ACK   = 5'd5,
        PH_TX_REL     = 5'd6,
        PH_TX_START   = 5'd7,
        PH_TX_GAP     = 5'd8,
        PH_BIT_SETUP  = 5'd9,
        PH_BIT_CLOW   = 5'd10,
        PH_BIT_CHIGH  = 5'd11,
        PH_TX_ACK     = 5'd12,
        PH_RST_HOLD   = 5'd13
    } phase_t;

    typedef enum logic [1:0] {
        KS_NONE     = 2'd0,
        KS_ACCEPTED = 2'd1,
        KS_REJECTED = 2'd2
    } key_status_t;

    typedef enum logic [1:0] {
        REG_PHASE_TICKS = 2'd0,
        REG_GAP_TICKS   = 2'd1,
        REG_ACK_TIMEOUT = 2'd2,
        REG_RESET_HOLD  = 2'd3
    } reg_index_t;

    localparam logic [6:0] CAPS_CODE       = 7'h62;
    localparam logic [7:0] INIT_CODE       = 8'hFB;
    localparam logic [7:0] TERM_CODE       = 8'hFD;
    localparam logic [7:0] BAD_CODE        = 8'hF3;

    localparam logic [9:0]  PHASE_TICKS_RST = 10'd20;
    localparam logic [9:0]  GAP_TICKS_RST   = 10'd100;
    localparam logic [19:0] ACK_TIMEOUT_RST = 20'd143000;
    localparam logic [19:0] RESET_HOLD_RST  = 20'd500000;

endpackage

### hdl/keyboard_serial_link_transmitter.sv
// Keyboard serial link transmitter: key FIFO in RAM and timed line sequencer.
// A result beat is registered and valid in the cycle after its input beat is taken.
// Throughput: one beat per cycle unless output stalls. The code RAM is read every
// beat for the next head; the read is registered, a head-slot write is forwarded.
// Reset (aresetn low, synchronous) restores the register defaults, idles the
// sequencer and preloads the two start codes through flags, not RAM writes.
module keyboard_serial_link_transmitter #(
    parameter int FIFO_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // key_valid[0], key_code[7:1], key_pressed[8], reset_request[9], data_line_in[10]
    input  logic [15:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // clock_line[0], data_line_out[1], reset_line[2], caps_led[3],
    // key_status[5:4], link_synced[6]
    output logic [7:0]  m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kslt_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PRELOAD_WP   = (FIFO_DEPTH > 2) ? PTR_W'(2) : PTR_W'(1);
    localparam logic [1:0]       PRELOAD_MASK = (FIFO_DEPTH > 2) ? 2'b11 : 2'b01;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    logic [9:0]  phase_ticks_reg;
    logic [9:0]  gap_ticks_reg;
    logic [19:0] ack_timeout_reg;
    logic [19:0] reset_hold_reg;

    phase_t           phase_reg, phase_next;
    logic [19:0]      wc_reg, wc_next;
    logic [2:0]       bit_index_reg, bit_index_next;
    logic [7:0]       shift_reg, shift_next;
    logic             sbc_reg, sbc_next;
    logic             synced_reg, synced_next;
    logic             retrans_reg, retrans_next;
    logic             caps_reg, caps_next;
    logic             led_reg, led_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [1:0]       pre_valid_reg, pre_valid_next;

    logic [7:0]       code_mem [FIFO_DEPTH];
    logic [7:0]       mem_q_reg;
    logic             fwd_reg;
    logic [7:0]       fwd_data_reg;

    logic             m_tvalid_reg;
    logic [7:0]       m_tdata_reg;

    logic             step;
    logic             cfg_wr;
    logic             key_valid, key_pressed, reset_request, din;
    logic [6:0]       key_code;

    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic [7:0]       head;
    logic [19:0]      ph_len, ack_len, hold_len, wc_dec;
    logic             timed_done;
    key_status_t      status;
    logic             clk_out, dout_out;

    assign key_valid     = s_tdata[0];
    assign key_code      = s_tdata[7:1];
    assign key_pressed   = s_tdata[8];
    assign reset_request = s_tdata[9];
    assign din           = s_tdata[10];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign step     = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RST;
            gap_ticks_reg   <= GAP_TICKS_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
            reset_hold_reg  <= RESET_HOLD_RST;
        end else if (cfg_wr) begin
            unique case (reg_index_t'(paddr[3:2]))
                REG_PHASE_TICKS: phase_ticks_reg <= pwdata[9:0];
                REG_GAP_TICKS:   gap_ticks_reg   <= pwdata[9:0];
                REG_ACK_TIMEOUT: ack_timeout_reg <= pwdata[19:0];
                REG_RESET_HOLD:  reset_hold_reg  <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index_t'(paddr[3:2]))
            REG_PHASE_TICKS: prdata = {22'd0, phase_ticks_reg};
            REG_GAP_TICKS:   prdata = {22'd0, gap_ticks_reg};
            REG_ACK_TIMEOUT: prdata = {12'd0, ack_timeout_reg};
            REG_RESET_HOLD:  prdata = {12'd0, reset_hold_reg};
            default:         prdata = '0;
        endcase
    end

    // head of queue: preload flags, then forwarded write, then RAM
    always_comb begin
        if (pre_valid_reg[0] && rp_reg == PTR_W'(0)) begin
            head = INIT_CODE;
        end else if (pre_valid_reg[1] && rp_reg == PTR_W'(1)) begin
            head = TERM_CODE;
        end else if (fwd_reg) begin
            head = fwd_data_reg;
        end else begin
            head = mem_q_reg;
        end
    end

    assign ph_len     = (phase_ticks_reg == 10'd0) ? 20'd1 : {10'd0, phase_ticks_reg};
    assign ack_len    = (ack_timeout_reg == 20'd0) ? 20'd1 : ack_timeout_reg;
    assign hold_len   = (reset_hold_reg == 20'd0) ? 20'd1 : reset_hold_reg;
    assign wc_dec     = (wc_reg == 20'd0) ? 20'd0 : wc_reg - 20'd1;
    assign timed_done = (wc_reg <= 20'd1);

    // next state of one tick
    always_comb begin
        logic       pr;
        logic [7:0] code8;
        phase_next     = phase_reg;
        wc_next        = wc_reg;
        bit_index_next = bit_index_reg;
        shift_next     = shift_reg;
        sbc_next       = sbc_reg;
        synced_next    = synced_reg;
        retrans_next   = retrans_reg;
        caps_next      = caps_reg;
        led_next       = led_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        pre_valid_next = pre_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_wdata      = '0;
        status         = KS_NONE;
        pr             = key_pressed;
        code8          = '0;

        if (reset_request && phase_reg != PH_RST_HOLD) begin
            wp_next    = '0;
            rp_next    = '0;
            sbc_next   = 1'b0;
            phase_next = PH_RST_HOLD;
            wc_next    = hold_len;
        end else begin
            unique case (phase_reg) inside
                PH_IDLE: begin
                    if (!synced_reg) begin
                        phase_next = PH_SYNC_REL;
                        wc_next    = '0;
                    end else if (rp_reg != wp_reg) begin
                        shift_next = head;
                        sbc_next   = 1'b0;
                        phase_next = PH_TX_REL;
                        wc_next    = ack_len;
                    end
                end
                PH_SYNC_REL: begin
                    if (din) begin
                        phase_next = PH_SYNC_DLOW;
                        wc_next    = ph_len;
                    end
                end
                PH_SYNC_DLOW: begin
                    wc_next = wc_dec;
                    if (timed_done) begin
                        phase_next = PH_SYNC_CLOW;
                        wc_next    = ph_len;
                    end
                end
                PH_SYNC_CLOW: begin
                    wc_next = wc_dec;
                    if (timed_done) begin
                        phase_next = PH_SYNC_CHIGH;
                        wc_next    = ph_len;
                    end
                end
                PH_SYNC_CHIGH: begin
                    wc_next = wc_dec;
                    if (timed_done) begin
                        phase_next = PH_SYNC_ACK;
                        wc_next    = ack_len;
                    end
                end
                PH_SYNC_ACK: begin
                    if (!din) begin
                        synced_next = 1'b1;
                        led_next    = caps_reg;
                        if (retrans_reg) begin
                            shift_next = BAD_CODE;
                            sbc_next   = 1'b1;
                            phase_next = PH_TX_REL;
                            wc_next    = ack_len;
                        end else begin
                            phase_next = PH_IDLE;
                            wc_next    = '0;
                        end
                    end else begin
                        wc_next = wc_dec;
                        if (timed_done) begin
                            phase_next = PH_SYNC_DLOW;
                            wc_next    = ph_len;
                        end
                    end
                end
                PH_TX_REL, PH_TX_ACK: begin
                    if (!din && phase_reg == PH_TX_ACK) begin
                        if (sbc_reg) begin
                            sbc_next = 1'b0;
                        end else if (rp_reg != wp_reg) begin
                            rp_next = next_slot(rp_reg);
                        end
                        phase_next = PH_IDLE;
                        wc_next    = '0;
                    end else if (din && phase_reg == PH_TX_REL) begin
                        bit_index_next = '0;
                        phase_next     = PH_TX_START;
                        wc_next        = ph_len;
                    end else begin
                        wc_next = wc_dec;
                        if (timed_done) begin
                            synced_next = 1'b0;
                            if (!sbc_reg) begin
                                retrans_next = 1'b1;
                            end
                            sbc_next   = 1'b0;
                            phase_next = PH_IDLE;
                            wc_next    = '0;
                        end
                    end
                end
                PH_TX_START: begin
                    wc_next = wc_dec;
                    if (timed_done) begin
                        bit_index_next = '0;
                        if (gap_ticks_reg == 10'd0) begin
                            phase_next = PH_BIT_SETUP;
                            wc_next    = ph_len;
                        end else begin
                            phase_next = PH_TX_GAP;
                            wc_next    = {10'd0, gap_ticks_reg};
                        end
                    end
                end
                PH_TX_GAP: begin
                    wc_next = wc_dec;
                    if (timed_done) begin
                        phase_next = PH_BIT_SETUP;
                        wc_next    = ph_len;
                    end
                end
                PH_BIT_SETUP: begin
                    wc_next = wc_dec;
                    if (timed_done) begin
                        phase_next = PH_BIT_CLOW;
                        wc_next    = ph_len;
                    end
                end
                PH_BIT_CLOW: begin
                    wc_next = wc_dec;
                    if (timed_done) begin
                        phase_next = PH_BIT_CHIGH;
                        wc_next    = ph_len;
                    end
                end
                PH_BIT_CHIGH: begin
                    wc_next = wc_dec;
                    if (timed_done) begin
                        if (bit_index_reg == 3'd7) begin
                            phase_next = PH_TX_ACK;
                            wc_next    = ack_len;
                        end else begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = PH_BIT_SETUP;
                            wc_next        = ph_len;
                        end
                    end
                end
                PH_RST_HOLD: begin
                    wc_next = wc_dec;
                    if (timed_done) begin
                        wp_next        = PRELOAD_WP;
                        rp_next        = '0;
                        pre_valid_next = PRELOAD_MASK;
                        synced_next    = 1'b0;
                        retrans_next   = 1'b0;
                        caps_next      = 1'b0;
                        led_next       = 1'b1;
                        sbc_next       = 1'b0;
                        phase_next     = PH_IDLE;
                        wc_next        = '0;
                        bit_index_next = '0;
                        shift_next     = '0;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    wc_next    = '0;
                end
            endcase
        end

        // key event, seen after the sequencer tick
        if (key_valid) begin
            if (phase_next == PH_RST_HOLD) begin
                status = KS_REJECTED;
            end else if (key_code == CAPS_CODE && !key_pressed) begin
                status = KS_ACCEPTED;
            end else begin
                if (key_code == CAPS_CODE) begin
                    caps_next = !caps_next;
                    led_next  = caps_next;
                    pr        = caps_next;
                end
                code8 = {key_code, !pr};
                if (next_slot(wp_next) == rp_next) begin
                    status = KS_REJECTED;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = wp_next;
                    mem_wdata = code8;
                    if (wp_next == PTR_W'(0)) begin
                        pre_valid_next[0] = 1'b0;
                    end
                    if (wp_next == PTR_W'(1)) begin
                        pre_valid_next[1] = 1'b0;
                    end
                    wp_next = next_slot(wp_next);
                    status  = KS_ACCEPTED;
                end
            end
        end
    end

    // line levels after the tick
    always_comb begin
        clk_out  = 1'b1;
        dout_out = 1'b1;
        unique case (phase_next) inside
            PH_SYNC_DLOW, PH_SYNC_CHIGH, PH_TX_START: begin
                dout_out = 1'b0;
            end
            PH_SYNC_CLOW: begin
                dout_out = 1'b0;
                clk_out  = 1'b0;
            end
            PH_BIT_SETUP, PH_BIT_CHIGH: begin
                dout_out = !shift_next[3'd7 - bit_index_next];
            end
            PH_BIT_CLOW: begin
                dout_out = !shift_next[3'd7 - bit_index_next];
                clk_out  = 1'b0;
            end
            default: ;
        endcase
    end

    // code RAM, read ahead at the next head slot
    always_ff @(posedge aclk) begin
        if (step) begin
            if (mem_we) begin
                code_mem[mem_waddr] <= mem_wdata;
            end
            mem_q_reg    <= code_mem[rp_next];
            fwd_data_reg <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            wc_reg        <= '0;
            bit_index_reg <= '0;
            shift_reg     <= '0;
            sbc_reg       <= 1'b0;
            synced_reg    <= 1'b0;
            retrans_reg   <= 1'b0;
            caps_reg      <= 1'b0;
            led_reg       <= 1'b1;
            wp_reg        <= PRELOAD_WP;
            rp_reg        <= '0;
            pre_valid_reg <= PRELOAD_MASK;
            fwd_reg       <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            wc_reg        <= wc_next;
            bit_index_reg <= bit_index_next;
            shift_reg     <= shift_next;
            sbc_reg       <= sbc_next;
            synced_reg    <= synced_next;
            retrans_reg   <= retrans_next;
            caps_reg      <= caps_next;
            led_reg       <= led_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            pre_valid_reg <= pre_valid_next;
            fwd_reg       <= mem_we && (mem_waddr == rp_next);
        end
    end

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_tdata_reg <= {1'b0, synced_next, status, led_next,
                            (phase_next != PH_RST_HOLD), dout_out, clk_out};
        end
    end

    a_hold_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_RST_HOLD |-> wp_reg == '0 && rp_reg == '0)
        else $error("queue not empty during reset hold");

    a_bad_code_ctx: assert property (@(posedge aclk) disable iff (!aresetn)
        sbc_reg |-> retrans_reg && synced_reg)
        else $error("bad-code send without retransmit or sync");

    a_bits_synced: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BIT_SETUP || phase_reg == PH_BIT_CLOW ||
         phase_reg == PH_BIT_CHIGH) |-> synced_reg)
        else $error("data bits sent while unsynchronised");

    a_timer_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SYNC_DLOW || phase_reg == PH_SYNC_CLOW ||
         phase_reg == PH_TX_GAP || phase_reg == PH_TX_ACK ||
         phase_reg == PH_RST_HOLD) |-> wc_reg != '0)
        else $error("timed phase with expired counter");

endmodule

### dv/keyboard_link_checker.sv
`timescale 1ns / 1ps
// Checker for the keyboard serial link transmitter: predicts each result beat and compares it.
module keyboard_link_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          beats_checked,
    output int          codes_sent,
    output int          bad_codes_sent,
    output int          link_failures,
    output int          keys_rejected,
    output int          caps_toggles,
    output int          resets_taken
);
    import kslt_pkg::*;

    localparam int DEPTH = 32;
    localparam int PW = $clog2(DEPTH);

    typedef struct packed {
        logic        clk_line;
        logic        data_out;
        logic        rst_line;
        logic        led;
        key_status_t status;
        logic        synced;
    } link_out_t;

    // register copies
    logic [9:0]  phase_len;
    logic [9:0]  gap_len;
    logic [19:0] ack_limit;
    logic [19:0] hold_len;

    // predicted block state
    logic [7:0]    key_ring [DEPTH];
    logic [PW-1:0] wr_ptr;
    logic [PW-1:0] rd_ptr;
    logic          link_up;
    logic          resend_pending;
    logic          caps_state;
    logic          led_state;
    logic          bad_code_active;
    phase_t        seq_phase;
    logic [19:0]   tick_count;
    logic [2:0]    bit_pos;
    logic [7:0]    tx_byte;

    link_out_t expected_lines [$];

    function logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function logic [19:0] nonzero(input logic [19:0] v);
        return (v == 20'd0) ? 20'd1 : v;
    endfunction

    function bit queue_code(input logic [7:0] c);
        if (ring_next(wr_ptr) == rd_ptr)
            return 1'b0;
        key_ring[wr_ptr] = c;
        wr_ptr = ring_next(wr_ptr);
        return 1'b1;
    endfunction

    function bit count_down();
        if (tick_count == 20'd0)
            return 1'b1;
        tick_count = tick_count - 20'd1;
        return tick_count == 20'd0;
    endfunction

    task enter_phase(input phase_t p);
        seq_phase = p;
        case (p) inside
            PH_SYNC_DLOW, PH_SYNC_CLOW, PH_SYNC_CHIGH, PH_TX_START,
            PH_BIT_SETUP, PH_BIT_CLOW, PH_BIT_CHIGH: begin
                tick_count = nonzero({10'd0, phase_len});
            end
            PH_TX_GAP: begin
                if (gap_len == 10'd0) begin
                    seq_phase = PH_BIT_SETUP;
                    tick_count = nonzero({10'd0, phase_len});
                end else begin
                    tick_count = {10'd0, gap_len};
                end
            end
            PH_SYNC_ACK, PH_TX_REL, PH_TX_ACK: begin
                tick_count = nonzero(ack_limit);
            end
            PH_RST_HOLD: begin
                tick_count = nonzero(hold_len);
            end
            default: begin
                tick_count = 20'd0;
            end
        endcase
    endtask

    task restart_link();
        wr_ptr = '0;
        rd_ptr = '0;
        link_up = 1'b0;
        resend_pending = 1'b0;
        caps_state = 1'b0;
        led_state = 1'b1;
        bad_code_active = 1'b0;
        enter_phase(PH_IDLE);
        bit_pos = 3'd0;
        tx_byte = 8'd0;
        void'(queue_code(INIT_CODE));
        void'(queue_code(TERM_CODE));
    endtask

    task link_fail();
        link_up = 1'b0;
        if (!bad_code_active)
            resend_pending = 1'b1;
        bad_code_active = 1'b0;
        link_failures++;
        enter_phase(PH_IDLE);
    endtask

    task link_done();
        if (bad_code_active) begin
            bad_code_active = 1'b0;
            bad_codes_sent++;
        end else if (rd_ptr != wr_ptr) begin
            rd_ptr = ring_next(rd_ptr);
            codes_sent++;
        end
        enter_phase(PH_IDLE);
    endtask

    task link_tick(input logic din);
        case (seq_phase)
            PH_IDLE: begin
                if (!link_up) begin
                    enter_phase(PH_SYNC_REL);
                end else if (rd_ptr != wr_ptr) begin
                    tx_byte = key_ring[rd_ptr];
                    bad_code_active = 1'b0;
                    enter_phase(PH_TX_REL);
                end
            end
            PH_SYNC_REL: begin
                if (din)
                    enter_phase(PH_SYNC_DLOW);
            end
            PH_SYNC_DLOW: begin
                if (count_down())
                    enter_phase(PH_SYNC_CLOW);
            end
            PH_SYNC_CLOW: begin
                if (count_down())
                    enter_phase(PH_SYNC_CHIGH);
            end
            PH_SYNC_CHIGH: begin
                if (count_down())
                    enter_phase(PH_SYNC_ACK);
            end
            PH_SYNC_ACK: begin
                if (!din) begin
                    link_up = 1'b1;
                    led_state = caps_state;
                    if (resend_pending) begin
                        tx_byte = BAD_CODE;
                        bad_code_active = 1'b1;
                        enter_phase(PH_TX_REL);
                    end else begin
                        enter_phase(PH_IDLE);
                    end
                end else if (count_down()) begin
                    enter_phase(PH_SYNC_DLOW);
                end
            end
            PH_TX_REL: begin
                if (din) begin
                    bit_pos = 3'd0;
                    enter_phase(PH_TX_START);
                end else if (count_down()) begin
                    link_fail();
                end
            end
            PH_TX_START: begin
                if (count_down()) begin
                    bit_pos = 3'd0;
                    enter_phase(PH_TX_GAP);
                end
            end
            PH_TX_GAP: begin
                if (count_down())
                    enter_phase(PH_BIT_SETUP);
            end
            PH_BIT_SETUP: begin
                if (count_down())
                    enter_phase(PH_BIT_CLOW);
            end
            PH_BIT_CLOW: begin
                if (count_down())
                    enter_phase(PH_BIT_CHIGH);
            end
            PH_BIT_CHIGH: begin
                if (count_down()) begin
                    if (bit_pos == 3'd7) begin
                        enter_phase(PH_TX_ACK);
                    end else begin
                        bit_pos = bit_pos + 3'd1;
                        enter_phase(PH_BIT_SETUP);
                    end
                end
            end
            PH_TX_ACK: begin
                if (!din)
                    link_done();
                else if (count_down())
                    link_fail();
            end
            PH_RST_HOLD: begin
                if (count_down())
                    restart_link();
            end
            default: begin
                enter_phase(PH_IDLE);
            end
        endcase
    endtask

    // one tick: reset request or sequencer step, then the key event, then the line levels
    task step_link(input logic [15:0] beat, output link_out_t res);
        logic        kvalid;
        logic [6:0]  code;
        logic        pressed;
        logic        rreq;
        logic        din;
        key_status_t st;
        kvalid = beat[0];
        code = beat[7:1];
        pressed = beat[8];
        rreq = beat[9];
        din = beat[10];
        st = KS_NONE;
        res.clk_line = 1'b1;
        res.data_out = 1'b1;

        if (rreq && seq_phase != PH_RST_HOLD) begin
            wr_ptr = '0;
            rd_ptr = '0;
            bad_code_active = 1'b0;
            enter_phase(PH_RST_HOLD);
            resets_taken++;
        end else begin
            link_tick(din);
        end

        if (kvalid) begin
            if (seq_phase == PH_RST_HOLD) begin
                st = KS_REJECTED;
            end else if (code == CAPS_CODE && !pressed) begin
                st = KS_ACCEPTED;
            end else begin
                if (code == CAPS_CODE) begin
                    caps_state = !caps_state;
                    led_state = caps_state;
                    pressed = caps_state;
                    caps_toggles++;
                end
                st = queue_code({code, !pressed}) ? KS_ACCEPTED : KS_REJECTED;
            end
            if (st == KS_REJECTED)
                keys_rejected++;
        end

        case (seq_phase) inside
            PH_SYNC_DLOW, PH_SYNC_CHIGH, PH_TX_START: begin
                res.data_out = 1'b0;
            end
            PH_SYNC_CLOW: begin
                res.data_out = 1'b0;
                res.clk_line = 1'b0;
            end
            PH_BIT_SETUP, PH_BIT_CLOW, PH_BIT_CHIGH: begin
                res.data_out = !tx_byte[3'd7 - bit_pos];
                if (seq_phase == PH_BIT_CLOW)
                    res.clk_line = 1'b0;
            end
            default: ;
        endcase

        res.rst_line = (seq_phase != PH_RST_HOLD);
        res.led = led_state;
        res.status = st;
        res.synced = link_up;
    endtask

    task store_reg(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            REG_PHASE_TICKS: phase_len = val[9:0];
            REG_GAP_TICKS:   gap_len = val[9:0];
            REG_ACK_TIMEOUT: ack_limit = val[19:0];
            REG_RESET_HOLD:  hold_len = val[19:0];
            default: ;
        endcase
    endtask

    task check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: result beat %0d, %s expected %0d, actual %0d",
                     $time, beats_checked, name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        link_out_t want;
        link_out_t got;
        if (!aresetn) begin
            phase_len = PHASE_TICKS_RST;
            gap_len = GAP_TICKS_RST;
            ack_limit = ACK_TIMEOUT_RST;
            hold_len = RESET_HOLD_RST;
            restart_link();
            expected_lines.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                store_reg(paddr[3:2], pwdata);
            if (s_tvalid && s_tready) begin
                step_link(s_tdata, want);
                expected_lines.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = link_out_t'({m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[3],
                                   m_tdata[5:4], m_tdata[6]});
                if (expected_lines.size() == 0) begin
                    $display("%0t: result beat %0h arrived with nothing expected",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_lines.pop_front();
                    check_field("clock_line", want.clk_line, got.clk_line);
                    check_field("data_line_out", want.data_out, got.data_out);
                    check_field("reset_line", want.rst_line, got.rst_line);
                    check_field("caps_led", want.led, got.led);
                    check_field("key_status", want.status, got.status);
                    check_field("link_synced", want.synced, got.synced);
                    beats_checked++;
                end
            end
        end
        pending = expected_lines.size();
    end

endmodule

### dv/keyboard_serial_link_transmitter_test.sv
`timescale 1ns / 1ps
// Top of the keyboard serial link transmitter test: clock, reset, stimulus and verdict.
module keyboard_serial_link_transmitter_test;
    import kslt_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [15:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count, pending, beats_checked, codes_sent, bad_codes_sent;
    int link_failures, keys_rejected, caps_toggles, resets_taken;

    int cycles = 0;
    int beats_sent = 0;
    int settings_used = 0;
    bit steady = 1'b0;
    bit long_hold_done = 1'b0;

    always #1 aclk = ~aclk;

    keyboard_serial_link_transmitter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    keyboard_link_checker link_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .pending        (pending),
        .beats_checked  (beats_checked),
        .codes_sent     (codes_sent),
        .bad_codes_sent (bad_codes_sent),
        .link_failures  (link_failures),
        .keys_rejected  (keys_rejected),
        .caps_toggles   (caps_toggles),
        .resets_taken   (resets_taken)
    );

    function automatic logic [15:0] pack_item(input logic kv, input logic [6:0] code,
                                              input logic pressed, input logic rreq,
                                              input logic din);
        return {5'b0, din, rreq, pressed, code, kv};
    endfunction

    function automatic logic [15:0] random_item(input int key_pct, input int rreq_pct,
                                                input int din_pct);
        logic [6:0] code;
        code = ($urandom_range(0, 99) < 15) ? CAPS_CODE : 7'($urandom_range(0, 127));
        return pack_item($urandom_range(0, 99) < key_pct, code, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 99) < rreq_pct, $urandom_range(0, 99) < din_pct);
    endfunction

    // mostly no pause, some short ones, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 70)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task send_beat(input logic [15:0] d, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        @(negedge aclk);
    endtask

    task reg_write(input reg_index_t idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
    endtask

    task drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    task apply_settings(input int unsigned ph, input int unsigned gap,
                        input int unsigned ack, input int unsigned hold);
        reg_write(REG_PHASE_TICKS, ph);
        reg_write(REG_GAP_TICKS, gap);
        reg_write(REG_ACK_TIMEOUT, ack);
        reg_write(REG_RESET_HOLD, hold);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    // kick: the first beat carries a reset request, aborting whatever is in flight
    task run_phase(input int unsigned ph, input int unsigned gap, input int unsigned ack,
                   input int unsigned hold, input int items, input int key_pct,
                   input int rreq_pct, input int din_pct, input bit kick, input bit quiet);
        drain();
        apply_settings(ph, gap, ack, hold);
        steady = quiet;
        if (kick)
            send_beat(random_item(key_pct, 100, din_pct), 0);
        repeat (items) send_beat(random_item(key_pct, rreq_pct, din_pct), idle_len());
        steady = 1'b0;
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("keyboard_serial_link_transmitter_test: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, and one long hold once traffic is flowing
    initial begin
        @(negedge aclk);
        forever begin
            int n;
            n = idle_len();
            if (!long_hold_done && beats_sent >= 300) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    initial begin : stimulus
        logic [15:0] directed [$];
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // reset values of the registers
        repeat (40) send_beat(random_item(50, 0, 60), idle_len());

        drain();
        apply_settings(1, 0, 2, 3);
        directed.push_back(pack_item(1'b1, 7'h00, 1'b1, 1'b0, 1'b1));
        directed.push_back(pack_item(1'b1, 7'h7F, 1'b0, 1'b0, 1'b0));
        directed.push_back(pack_item(1'b1, 7'h7F, 1'b1, 1'b0, 1'b1));
        directed.push_back(pack_item(1'b1, 7'h00, 1'b0, 1'b0, 1'b1));
        directed.push_back(pack_item(1'b1, CAPS_CODE, 1'b1, 1'b0, 1'b1));
        directed.push_back(pack_item(1'b1, CAPS_CODE, 1'b0, 1'b0, 1'b0));
        directed.push_back(pack_item(1'b1, CAPS_CODE, 1'b1, 1'b0, 1'b1));
        directed.push_back(pack_item(1'b1, CAPS_CODE, 1'b0, 1'b0, 1'b1));
        directed.push_back(pack_item(1'b0, 7'h00, 1'b0, 1'b0, 1'b0));
        directed.push_back(pack_item(1'b1, 7'h55, 1'b1, 1'b1, 1'b1));
        directed.push_back(pack_item(1'b1, 7'h2A, 1'b0, 1'b1, 1'b0));
        directed.push_back(pack_item(1'b1, 7'h7F, 1'b1, 1'b0, 1'b1));
        directed.push_back(pack_item(1'b0, 7'h7F, 1'b1, 1'b0, 1'b1));
        directed.push_back(pack_item(1'b0, 7'h00, 1'b0, 1'b0, 1'b0));
        directed.push_back(pack_item(1'b0, 7'h00, 1'b0, 1'b0, 1'b1));
        directed.push_back(pack_item(1'b1, 7'h01, 1'b1, 1'b0, 1'b1));
        directed.push_back(pack_item(1'b1, 7'h40, 1'b0, 1'b0, 1'b0));
        directed.push_back(pack_item(1'b0, 7'h00, 1'b0, 1'b1, 1'b1));
        directed.push_back(pack_item(1'b0, 7'h00, 1'b0, 1'b0, 1'b1));
        foreach (directed[i]) send_beat(directed[i], idle_len());

        // zero durations, then the top of every register range
        run_phase(0, 0, 0, 0, 120, 50, 2, 60, 1'b1, 1'b0);
        run_phase(1023, 1023, 1048575, 1048575, 60, 50, 0, 60, 1'b0, 1'b1);
        run_phase(2, 3, 6, 4, 150, 50, 1, 70, 1'b1, 1'b0);
        // tight timeouts: failed transfers, resync and bad-code resends
        run_phase(1, 1, 1, 1, 120, 40, 1, 50, 1'b0, 1'b0);
        // heavy key traffic against a slow link fills the queue
        run_phase(3, 0, 20, 10, 150, 85, 0, 80, 1'b0, 1'b0);
        run_phase(1, 2, 8, 30, 150, 60, 2, 65, 1'b0, 1'b1);
        run_phase($urandom_range(1, 4), $urandom_range(0, 6), $urandom_range(1, 16),
                  $urandom_range(1, 24), 160, 60, 1, 65, 1'b1, 1'b0);

        drain();
        repeat (10) @(negedge aclk);
        $display("Run covered %0d input beats, %0d results checked, %0d register settings.",
                 beats_sent, beats_checked, settings_used);
        $display("Codes sent %0d, bad-code resends %0d, failed transfers %0d, %0d %s %0d %s %0d",
                 codes_sent, bad_codes_sent, link_failures, keys_rejected,
                 "keys rejected, caps toggles", caps_toggles, "reset holds", resets_taken);
        if (fail_count == 0 && pending == 0)
            $display("keyboard_serial_link_transmitter_test: PASS");
        else
            $display("keyboard_serial_link_transmitter_test: FAIL");
        $finish;
    end

endmodule

### sim.f
hdl/kslt_pkg.sv
hdl/keyboard_serial_link_transmitter.sv
dv/keyboard_link_checker.sv
dv/keyboard_serial_link_transmitter_test.sv
